// ===== design/kobl_pkg.sv =====
// ----------------------------------------------------------------------------
// kobl_pkg: shared definitions for the keyed ordered block list
// Capacity, field widths, operation and status codes, the per-cell shift
// command and the decode record passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kobl_pkg;

  // Number of entries the list can hold (2 .. 127; entry_count is 7 bits wide).
  localparam int CAPACITY = 64;

  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int COUNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W         = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_COUNT_W = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_TAIL = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_HEAD = 3'd4;
  localparam logic [OP_W-1:0] OP_MOVE     = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_AT_HEAD = 3'd4;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_FROM_PREV = 2'd1,
    CELL_FROM_NEXT = 2'd2,
    CELL_LOAD_KEY  = 2'd3
  } cell_mode_t;

  // Source of the reported block number.
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_KEY  = 2'd1,
    RES_TAIL = 2'd2,
    RES_HEAD = 2'd3
  } res_sel_t;

  // Decoded action for one request.
  typedef struct packed {
    logic                ins_new;
    logic                ins_hit;
    logic                del_key;
    logic                pop_tail;
    logic                pop_head;
    logic                mov;
    logic                found;
    logic [STATUS_W-1:0] status;
    res_sel_t            res_sel;
  } dec_t;

endpackage

`default_nettype wire

// ===== design/keyed_ordered_block_list.sv =====
// ----------------------------------------------------------------------------
// keyed_ordered_block_list: ordered list of unique block numbers
// A taken request is held in the request register, decoded, and its result
//   registered; done is high for a single cycle with the result, and the
//   result is taken at the edge that ends that cycle.
// Throughput: one request every cycle; busy is low except during reset.
//   The key match, shift decision and next state are all combinational.
// Reset (rst, synchronous, active high) empties the list and drops any
//   request in flight. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_ordered_block_list (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [kobl_pkg::OP_W-1:0]            operation,
  input  wire logic [kobl_pkg::KEY_W-1:0]           block_number,
  output logic                                      done,
  output logic      [kobl_pkg::STATUS_W-1:0]        status,
  output logic                                      found,
  output logic      [kobl_pkg::KEY_W-1:0]           result_block,
  output logic      [kobl_pkg::ENTRY_COUNT_W-1:0]   entry_count
);

  localparam int N = kobl_pkg::CAPACITY;

  // The request register. A request is taken whenever start is high and
  // the block is out of reset; it is worked on during the following cycle.
  logic                          req_valid;
  logic [kobl_pkg::OP_W-1:0]     req_op;
  logic [kobl_pkg::KEY_W-1:0]    req_key;

  // Number of entries held. Entry i is valid exactly when i < count, so the
  // valid bits are a thermometer decode of the count.
  logic [kobl_pkg::COUNT_W-1:0]  count;
  logic [kobl_pkg::COUNT_W-1:0]  count_next;

  logic [kobl_pkg::KEY_W-1:0]    cell_key   [N];
  kobl_pkg::cell_mode_t          cell_mode  [N];
  logic [N-1:0]                  cell_valid;
  logic [N-1:0]                  cell_match;
  logic [N-1:0]                  cell_tail;

  logic [kobl_pkg::IDX_W-1:0]    hit_idx;
  logic [kobl_pkg::KEY_W-1:0]    tail_key;
  logic [kobl_pkg::KEY_W-1:0]    res_key;
  logic                          hit;
  logic                          empty;
  logic                          full;
  kobl_pkg::dec_t                dec;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
    req_op  <= operation;
    req_key <= block_number;
  end

  assign empty = (count == '0);
  assign full  = (count == kobl_pkg::COUNT_W'(N));
  assign hit   = |cell_match;

  // Keys are unique, so at most one cell matches and the position can be
  // formed by OR-ing the indices of the matching cells. The tail cell is the
  // last valid one; its key is picked out the same way.
  always_comb begin
    hit_idx  = '0;
    tail_key = '0;
    for (int i = 0; i < N; i++) begin
      if (cell_match[i]) begin
        hit_idx = hit_idx | kobl_pkg::IDX_W'(i);
      end
      if (cell_tail[i]) begin
        tail_key = tail_key | cell_key[i];
      end
    end
  end

  kobl_ctrl u_ctrl (
    .req_valid (req_valid),
    .req_op    (req_op),
    .hit       (hit),
    .hit_head  (cell_match[0]),
    .empty     (empty),
    .full      (full),
    .dec       (dec)
  );

  // Each cell's shift command. An insert moves entries toward the tail
  // (all of them for a new key, up to the old copy for a held key); a
  // delete or head pop closes the gap by moving later entries toward the
  // head. A move swaps the matched entry with its neighbour nearer the head.
  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam logic [kobl_pkg::IDX_W-1:0] IDX = kobl_pkg::IDX_W'(g);
    logic                         next_match;
    logic [kobl_pkg::KEY_W-1:0]   prev_key;
    logic [kobl_pkg::KEY_W-1:0]   next_key;

    assign cell_valid[g] = (kobl_pkg::COUNT_W'(g) < count);

    if (g == 0) begin : g_first
      assign prev_key = req_key;
    end else begin : g_inner_prev
      assign prev_key = cell_key[g-1];
    end

    if (g == N - 1) begin : g_last
      assign next_key   = '0;
      assign next_match = 1'b0;
      assign cell_tail[g] = cell_valid[g];
    end else begin : g_inner_next
      assign next_key     = cell_key[g+1];
      assign next_match   = cell_match[g+1];
      assign cell_tail[g] = cell_valid[g] && !cell_valid[g+1];
    end

    always_comb begin
      priority if (dec.ins_new || (dec.ins_hit && IDX <= hit_idx)) begin
        cell_mode[g] = kobl_pkg::CELL_FROM_PREV;
      end else if (dec.pop_head || (dec.del_key && IDX >= hit_idx)) begin
        cell_mode[g] = kobl_pkg::CELL_FROM_NEXT;
      end else if (dec.mov && cell_match[g]) begin
        cell_mode[g] = kobl_pkg::CELL_FROM_PREV;
      end else if (dec.mov && next_match) begin
        cell_mode[g] = kobl_pkg::CELL_LOAD_KEY;
      end else begin
        cell_mode[g] = kobl_pkg::CELL_HOLD;
      end
    end

    kobl_cell u_cell (
      .clk      (clk),
      .mode     (cell_mode[g]),
      .valid    (cell_valid[g]),
      .prev_key (prev_key),
      .next_key (next_key),
      .req_key  (req_key),
      .key      (cell_key[g]),
      .match    (cell_match[g])
    );
  end

  always_comb begin
    priority if (dec.ins_new) begin
      count_next = count + kobl_pkg::COUNT_W'(1);
    end else if (dec.del_key || dec.pop_head || dec.pop_tail) begin
      count_next = count - kobl_pkg::COUNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    unique case (dec.res_sel)
      kobl_pkg::RES_KEY:  res_key = req_key;
      kobl_pkg::RES_TAIL: res_key = tail_key;
      kobl_pkg::RES_HEAD: res_key = cell_key[0];
      default:            res_key = '0;
    endcase
  end

  // Count and result registers. The result is shown for one cycle only.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= req_valid;
    end
    status       <= dec.status;
    found        <= dec.found;
    result_block <= res_key;
    entry_count  <= kobl_pkg::ENTRY_COUNT_W'(count_next);
  end

  // Keys are kept unique, so no two cells may ever match together.
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_match))
    else $error("more than one cell matches the request key");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= kobl_pkg::COUNT_W'(N))
    else $error("entry count beyond capacity");

  // Every request gives exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    req_valid |=> done)
    else $error("request produced no result");

  // A refused insert leaves the count untouched.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (req_valid && dec.status == kobl_pkg::ST_FULL) |=> $stable(count))
    else $error("refused insert changed the count");

  // Nothing can be found in an empty list.
  a_empty_not_found: assert property (@(posedge clk) disable iff (rst)
    (req_valid && empty) |-> !hit)
    else $error("key matched in an empty list");

endmodule

`default_nettype wire

// ===== design/kobl_cell.sv =====
// ----------------------------------------------------------------------------
// kobl_cell: one list entry
// Holds one key, compares it with the request key and loads from its
// neighbours or from the request when the list shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module kobl_cell (
  input  wire logic                      clk,
  input  wire kobl_pkg::cell_mode_t      mode,
  input  wire logic                      valid,
  input  wire logic [kobl_pkg::KEY_W-1:0] prev_key,
  input  wire logic [kobl_pkg::KEY_W-1:0] next_key,
  input  wire logic [kobl_pkg::KEY_W-1:0] req_key,
  output logic      [kobl_pkg::KEY_W-1:0] key,
  output logic                           match
);

  logic [kobl_pkg::KEY_W-1:0] key_next;

  assign match = valid && (key == req_key);

  always_comb begin
    unique case (mode)
      kobl_pkg::CELL_FROM_PREV: key_next = prev_key;
      kobl_pkg::CELL_FROM_NEXT: key_next = next_key;
      kobl_pkg::CELL_LOAD_KEY:  key_next = req_key;
      default:                  key_next = key;
    endcase
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

`default_nettype wire

// ===== design/kobl_ctrl.sv =====
// ----------------------------------------------------------------------------
// kobl_ctrl: request decoder
// Turns the operation and the list condition into the action to take and
// the status to report.
// ----------------------------------------------------------------------------
`default_nettype none

module kobl_ctrl (
  input  wire logic                        req_valid,
  input  wire logic [kobl_pkg::OP_W-1:0]   req_op,
  input  wire logic                        hit,
  input  wire logic                        hit_head,
  input  wire logic                        empty,
  input  wire logic                        full,
  output kobl_pkg::dec_t                   dec
);

  always_comb begin
    dec         = '0;
    dec.status  = kobl_pkg::ST_OK;
    dec.res_sel = kobl_pkg::RES_NONE;
    if (req_valid) begin
      unique case (req_op)
        kobl_pkg::OP_LOOKUP: begin
          if (hit) begin
            dec.found   = 1'b1;
            dec.res_sel = kobl_pkg::RES_KEY;
          end else begin
            dec.status = empty ? kobl_pkg::ST_EMPTY : kobl_pkg::ST_MISSING;
          end
        end
        kobl_pkg::OP_INSERT: begin
          if (hit) begin
            dec.found   = 1'b1;
            dec.res_sel = kobl_pkg::RES_KEY;
            dec.ins_hit = 1'b1;
          end else if (full) begin
            dec.status = kobl_pkg::ST_FULL;
          end else begin
            dec.ins_new = 1'b1;
          end
        end
        kobl_pkg::OP_DELETE: begin
          if (empty) begin
            dec.status = kobl_pkg::ST_EMPTY;
          end else if (!hit) begin
            dec.status = kobl_pkg::ST_MISSING;
          end else begin
            dec.found   = 1'b1;
            dec.res_sel = kobl_pkg::RES_KEY;
            dec.del_key = 1'b1;
          end
        end
        kobl_pkg::OP_POP_TAIL: begin
          if (empty) begin
            dec.status = kobl_pkg::ST_EMPTY;
          end else begin
            dec.res_sel  = kobl_pkg::RES_TAIL;
            dec.pop_tail = 1'b1;
          end
        end
        kobl_pkg::OP_POP_HEAD: begin
          if (empty) begin
            dec.status = kobl_pkg::ST_EMPTY;
          end else begin
            dec.res_sel  = kobl_pkg::RES_HEAD;
            dec.pop_head = 1'b1;
          end
        end
        kobl_pkg::OP_MOVE: begin
          if (empty) begin
            dec.status = kobl_pkg::ST_EMPTY;
          end else if (!hit) begin
            dec.status = kobl_pkg::ST_MISSING;
          end else begin
            dec.found   = 1'b1;
            dec.res_sel = kobl_pkg::RES_KEY;
            if (hit_head) begin
              dec.status = kobl_pkg::ST_AT_HEAD;
            end else begin
              dec.mov = 1'b1;
            end
          end
        end
        default: begin
          // Unused operation codes change nothing and report ok.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_keyed_ordered_block_list.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_ordered_block_list: self-checking bench for the keyed block list
// A short table of directed requests covers the empty list, the extremes of
// the key, every operation and the unused codes. Three random passes follow,
// each with a different amount of sender idling. An in-bench copy of the
// list predicts each result, and a monitor compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_ordered_block_list;

  // The two operation codes that the block accepts but ignores.
  localparam logic [kobl_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [kobl_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Reported mismatches before the bench falls silent and only counts.
  localparam int REPORT_LIMIT = 10;
  localparam int POOL_MAX     = 96;

  // One result as the block reports it.
  typedef struct {
    logic [kobl_pkg::STATUS_W-1:0]      status;
    logic                               found;
    logic [kobl_pkg::KEY_W-1:0]         number;
    logic [kobl_pkg::ENTRY_COUNT_W-1:0] count;
  } outcome_t;

  // One row of the directed table. Where typed is set, the outcome was read
  // straight off the behaviour and is used as the expectation.
  typedef struct {
    logic [kobl_pkg::OP_W-1:0]  op;
    logic [kobl_pkg::KEY_W-1:0] key;
    bit                         typed;
    outcome_t                   outcome;
  } request_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic [kobl_pkg::OP_W-1:0]          operation = '0;
  logic [kobl_pkg::KEY_W-1:0]         block_number = '0;
  logic                               busy;
  logic                               done;
  logic [kobl_pkg::STATUS_W-1:0]      status;
  logic                               found;
  logic [kobl_pkg::KEY_W-1:0]         result_block;
  logic [kobl_pkg::ENTRY_COUNT_W-1:0] entry_count;

  // The bench's own copy of the list, head at index zero.
  logic [kobl_pkg::KEY_W-1:0] list_keys [kobl_pkg::CAPACITY];
  int                         list_len = 0;

  outcome_t                   pending_results [$];
  request_row_t               directed_rows [$];
  logic [kobl_pkg::KEY_W-1:0] key_pool [POOL_MAX];
  int                         error_count = 0;

  keyed_ordered_block_list dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .block_number (block_number),
    .done         (done),
    .status       (status),
    .found        (found),
    .result_block (result_block),
    .entry_count  (entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fixed safety net: far beyond the slowest correct run.
  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Drops the entry at pos; the entries behind it close up toward the head.
  task automatic drop_entry(input int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      list_keys[i] = list_keys[i + 1];
    end
    list_len--;
  endtask

  // Puts key at the head; every entry moves one place toward the tail.
  task automatic place_at_head(input logic [kobl_pkg::KEY_W-1:0] key);
    for (int i = list_len; i > 0; i--) begin
      list_keys[i] = list_keys[i - 1];
    end
    list_keys[0] = key;
    list_len++;
  endtask

  // Applies one request to the bench's list and works out what the block
  // should report for it.
  task automatic apply_to_list(input logic [kobl_pkg::OP_W-1:0] op,
                               input logic [kobl_pkg::KEY_W-1:0] key,
                               output outcome_t res);
    int pos;
    pos = -1;
    res.status = kobl_pkg::ST_OK;
    res.found  = 1'b0;
    res.number = '0;
    for (int i = 0; i < list_len; i++) begin
      if (pos < 0 && list_keys[i] == key) begin
        pos = i;
      end
    end
    case (op)
      kobl_pkg::OP_LOOKUP: begin
        if (pos >= 0) begin
          res.found  = 1'b1;
          res.number = key;
        end else begin
          res.status = (list_len == 0) ? kobl_pkg::ST_EMPTY : kobl_pkg::ST_MISSING;
        end
      end
      kobl_pkg::OP_INSERT: begin
        if (pos >= 0) begin
          // A held key is taken out and put back at the head.
          res.found  = 1'b1;
          res.number = key;
          drop_entry(pos);
          place_at_head(key);
        end else if (list_len >= kobl_pkg::CAPACITY) begin
          res.status = kobl_pkg::ST_FULL;
        end else begin
          place_at_head(key);
        end
      end
      kobl_pkg::OP_DELETE: begin
        if (list_len == 0) begin
          res.status = kobl_pkg::ST_EMPTY;
        end else if (pos < 0) begin
          res.status = kobl_pkg::ST_MISSING;
        end else begin
          res.found  = 1'b1;
          res.number = key;
          drop_entry(pos);
        end
      end
      kobl_pkg::OP_POP_TAIL: begin
        if (list_len == 0) begin
          res.status = kobl_pkg::ST_EMPTY;
        end else begin
          res.number = list_keys[list_len - 1];
          drop_entry(list_len - 1);
        end
      end
      kobl_pkg::OP_POP_HEAD: begin
        if (list_len == 0) begin
          res.status = kobl_pkg::ST_EMPTY;
        end else begin
          res.number = list_keys[0];
          drop_entry(0);
        end
      end
      kobl_pkg::OP_MOVE: begin
        if (list_len == 0) begin
          res.status = kobl_pkg::ST_EMPTY;
        end else if (pos < 0) begin
          res.status = kobl_pkg::ST_MISSING;
        end else begin
          res.found  = 1'b1;
          res.number = key;
          if (pos == 0) begin
            res.status = kobl_pkg::ST_AT_HEAD;
          end else begin
            // Swap with the entry one place nearer the head.
            list_keys[pos]     = list_keys[pos - 1];
            list_keys[pos - 1] = key;
          end
        end
      end
      default: begin
        // The unused codes leave the list alone and report only the count.
      end
    endcase
    res.count = list_len[kobl_pkg::ENTRY_COUNT_W-1:0];
  endtask

  // Presents one request, idling the sender first at the given rate, and
  // records the expected result once the block has taken it.
  task automatic issue_request(input logic [kobl_pkg::OP_W-1:0] op,
                               input logic [kobl_pkg::KEY_W-1:0] key,
                               input bit typed, input outcome_t typed_res,
                               input int idle_pct);
    outcome_t res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    block_number <= key;
    // A request is taken at an edge where start is high and busy is low.
    do begin
      @(posedge clk);
    end while (busy);
    apply_to_list(op, key, res);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic add_row(input logic [kobl_pkg::OP_W-1:0] op,
                         input logic [kobl_pkg::KEY_W-1:0] key,
                         input bit typed, input logic [kobl_pkg::STATUS_W-1:0] st,
                         input logic fnd, input logic [kobl_pkg::KEY_W-1:0] num,
                         input logic [kobl_pkg::ENTRY_COUNT_W-1:0] cnt);
    request_row_t row;
    row.op             = op;
    row.key            = key;
    row.typed          = typed;
    row.outcome.status = st;
    row.outcome.found  = fnd;
    row.outcome.number = num;
    row.outcome.count  = cnt;
    directed_rows.push_back(row);
  endtask

  // Picks an operation; inserts come at the given rate, and a few requests
  // use the codes that the block ignores.
  function automatic logic [kobl_pkg::OP_W-1:0] pick_operation(input int insert_pct);
    logic [kobl_pkg::OP_W-1:0] op;
    if ($urandom_range(99) < insert_pct) begin
      op = kobl_pkg::OP_INSERT;
    end else if ($urandom_range(99) < 4) begin
      op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
    end else begin
      case ($urandom_range(4))
        0: op = kobl_pkg::OP_LOOKUP;
        1: op = kobl_pkg::OP_DELETE;
        2: op = kobl_pkg::OP_POP_TAIL;
        3: op = kobl_pkg::OP_POP_HEAD;
        default: op = kobl_pkg::OP_MOVE;
      endcase
    end
    return op;
  endfunction

  // Result monitor. Results cannot be held off, so every strobe is taken at
  // the edge that ends its cycle and compared with the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with none expected: st %0d fnd %0b blk %h cnt %0d",
                               status, found, result_block, entry_count));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || found !== want.found ||
            result_block !== want.number || entry_count !== want.count) begin
          note_failure($sformatf(
            "expected st %0d fnd %0b blk %h cnt %0d, got st %0d fnd %0b blk %h cnt %0d",
            want.status, want.found, want.number, want.count,
            status, found, result_block, entry_count));
        end
      end
    end
  end

  initial begin
    int                         idle_by_pass [3];
    int                         chunk_len    [3];
    int                         chunk_pool   [3];
    int                         chunk_insert [3];
    int                         pool_size;
    logic [kobl_pkg::KEY_W-1:0] key;
    outcome_t                   no_res;

    no_res = '{kobl_pkg::ST_OK, 1'b0, '0, '0};

    // Sender idling per pass: light, heavy, then none at all.
    idle_by_pass = '{26, 81, 0};
    // Each pass churns a small list, then fills it past capacity with many
    // distinct keys, then drains it with few inserts.
    chunk_len    = '{60, 120, 120};
    chunk_pool   = '{12, 96, 96};
    chunk_insert = '{30, 85, 5};

    // Directed table: the empty list, both key extremes, every operation,
    // a move of the head, re-insert of a held key and the unused codes.
    add_row(kobl_pkg::OP_LOOKUP,   32'h0000_0000, 1, kobl_pkg::ST_EMPTY,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_DELETE,   32'h0000_0001, 1, kobl_pkg::ST_EMPTY,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_MOVE,     32'h0000_0002, 1, kobl_pkg::ST_EMPTY,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_POP_TAIL, 32'h0000_0000, 1, kobl_pkg::ST_EMPTY,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_POP_HEAD, 32'h0000_0000, 1, kobl_pkg::ST_EMPTY,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_INSERT,   32'hFFFF_FFFF, 1, kobl_pkg::ST_OK,
            1'b0, 32'h0000_0000, 7'd1);
    add_row(kobl_pkg::OP_INSERT,   32'h0000_0000, 1, kobl_pkg::ST_OK,
            1'b0, 32'h0000_0000, 7'd2);
    add_row(kobl_pkg::OP_LOOKUP,   32'hFFFF_FFFF, 1, kobl_pkg::ST_OK,
            1'b1, 32'hFFFF_FFFF, 7'd2);
    add_row(kobl_pkg::OP_LOOKUP,   32'h0000_0005, 1, kobl_pkg::ST_MISSING,
            1'b0, 32'h0000_0000, 7'd2);
    add_row(kobl_pkg::OP_MOVE,     32'h0000_0000, 1, kobl_pkg::ST_AT_HEAD,
            1'b1, 32'h0000_0000, 7'd2);
    add_row(kobl_pkg::OP_MOVE,     32'hFFFF_FFFF, 1, kobl_pkg::ST_OK,
            1'b1, 32'hFFFF_FFFF, 7'd2);
    add_row(kobl_pkg::OP_INSERT,   32'h0000_0000, 1, kobl_pkg::ST_OK,
            1'b1, 32'h0000_0000, 7'd2);
    add_row(OP_SPARE_LO,           32'h1234_5678, 1, kobl_pkg::ST_OK,
            1'b0, 32'h0000_0000, 7'd2);
    add_row(OP_SPARE_HI,           32'h0000_0000, 1, kobl_pkg::ST_OK,
            1'b0, 32'h0000_0000, 7'd2);
    add_row(kobl_pkg::OP_DELETE,   32'h0000_0005, 1, kobl_pkg::ST_MISSING,
            1'b0, 32'h0000_0000, 7'd2);
    add_row(kobl_pkg::OP_MOVE,     32'h0000_0005, 1, kobl_pkg::ST_MISSING,
            1'b0, 32'h0000_0000, 7'd2);
    add_row(kobl_pkg::OP_INSERT,   32'hAAAA_AAAA, 0, kobl_pkg::ST_OK,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_INSERT,   32'h5555_5555, 0, kobl_pkg::ST_OK,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_MOVE,     32'h0000_0000, 0, kobl_pkg::ST_OK,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_POP_TAIL, 32'h0000_0000, 1, kobl_pkg::ST_OK,
            1'b0, 32'hFFFF_FFFF, 7'd3);
    add_row(kobl_pkg::OP_POP_HEAD, 32'h0000_0000, 1, kobl_pkg::ST_OK,
            1'b0, 32'h5555_5555, 7'd2);
    add_row(kobl_pkg::OP_DELETE,   32'hAAAA_AAAA, 1, kobl_pkg::ST_OK,
            1'b1, 32'hAAAA_AAAA, 7'd1);
    // The key of a pop is ignored, so a pop that carries one still removes
    // the last entry, zero.
    add_row(kobl_pkg::OP_POP_TAIL, 32'hFFFF_FFFF, 1, kobl_pkg::ST_OK,
            1'b0, 32'h0000_0000, 7'd0);
    add_row(kobl_pkg::OP_LOOKUP,   32'h0000_0000, 1, kobl_pkg::ST_EMPTY,
            1'b0, 32'h0000_0000, 7'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                    directed_rows[i].outcome, 0);
    end

    // Random passes. Keys mostly come from a pool so that hits, moves and
    // re-inserts are common; now and then a fresh key is used.
    for (int pass = 0; pass < 3; pass++) begin
      for (int chunk = 0; chunk < 3; chunk++) begin
        pool_size = chunk_pool[chunk];
        for (int i = 0; i < pool_size; i++) begin
          key_pool[i] = $urandom;
        end
        for (int n = 0; n < chunk_len[chunk]; n++) begin
          if ($urandom_range(9) == 0) begin
            key = $urandom;
          end else begin
            key = key_pool[$urandom_range(pool_size - 1)];
          end
          issue_request(pick_operation(chunk_insert[chunk]), key, 0, no_res,
                        idle_by_pass[pass]);
        end
      end
    end
    start <= 1'b0;

    // Let the last results come out, then a few more cycles to catch any
    // stray strobe.
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== keyed_ordered_block_list.f =====
design/kobl_pkg.sv
design/kobl_cell.sv
design/kobl_ctrl.sv
design/keyed_ordered_block_list.sv
verif/tb_keyed_ordered_block_list.sv
